[sv/rsga_pkg.sv]
// Shared types, widths and codes for the row seat group allocator.
package rsga_pkg;

   localparam int MAX_ROWS_DEF  = 64;
   localparam int MAX_SEATS_DEF = 1024;

   localparam int TAKEN_W    = 11;
   localparam int GROUP_W    = 17;
   localparam int ROWNUM_W   = 6;
   localparam int SEAT_W     = 10;
   localparam int ROWCNT_W   = 7;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 11;

   localparam logic [ROWCNT_W-1:0] ROWS_RESET  = 7'd64;
   localparam logic [TAKEN_W-1:0]  SEATS_RESET = 11'd1024;

   localparam logic [CSR_IDX_W-1:0] CSR_ROWS_IN_USE   = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_SEATS_PER_ROW = 1'b1;

   localparam logic REQ_GATHER  = 1'b0;
   localparam logic REQ_SCATTER = 1'b1;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_GATHER,
      ST_SUM,
      ST_FILL,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic               fits;
      logic [GROUP_W-1:0] left_next;
      logic [TAKEN_W-1:0] new_taken;
   } unit_res_type;

endpackage

[sv/row_seat_group_allocator_top.sv]
// Row seat group allocator: top level with configuration registers.
//
// Request channel (req_*): req_type 0 gathers req_group_size adjacent seats in
// the lowest row up to req_max_row with room; req_type 1 scatters them over
// rows 0..req_max_row in ascending order, or is denied if they lack room.
// Result channel (rsp_*): one item per request with granted, first row and
// first seat (row and seat are 0 for a scatter or a denial).
// Configuration (csr_*): write rows_in_use (index 0) or seats_per_row
// (index 1) while the block is idle.
// Timing: rows are read from the count memory one per cycle through its
// single read port and checked by one shared row unit. A gather scans the
// rows once, a scatter up to twice (a sum pass, then a fill pass). One item
// is worked on at a time; req_stall is high from acceptance until the result
// moves into the output register. Reset: a clearing pass zeroes the counts
// with req_stall high. A stalled result stays in the output register; the
// next item is taken meanwhile and its result waits until that register frees.
module row_seat_group_allocator_top #(
   parameter int MAX_ROWS  = rsga_pkg::MAX_ROWS_DEF,
   parameter int MAX_SEATS = rsga_pkg::MAX_SEATS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic                            req_type,
   input  logic [rsga_pkg::GROUP_W-1:0]    req_group_size,
   input  logic [rsga_pkg::ROWNUM_W-1:0]   req_max_row,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic                            rsp_granted,
   output logic [rsga_pkg::ROWNUM_W-1:0]   rsp_first_row,
   output logic [rsga_pkg::SEAT_W-1:0]     rsp_first_seat,
   input  logic                            csr_wr_en,
   input  logic [rsga_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [rsga_pkg::CSR_DATA_W-1:0] csr_wr_data
);
   import rsga_pkg::*;

   // only rows up to the widest max_row field are ever addressed
   localparam int MEM_ROWS = (MAX_ROWS < (2 ** ROWNUM_W)) ? MAX_ROWS : (2 ** ROWNUM_W);
   localparam int ADDR_W   = (MEM_ROWS > 1) ? $clog2(MEM_ROWS) : 1;

   logic [ROWCNT_W-1:0] csr_rows_ff, csr_rows_in;
   logic [TAKEN_W-1:0]  csr_seats_ff, csr_seats_in;
   logic [ROWCNT_W-1:0] rows_eff;
   logic [TAKEN_W-1:0]  seats_eff;

   logic                mem_wr_en;
   logic [ADDR_W-1:0]   mem_wr_addr;
   logic [TAKEN_W-1:0]  mem_wr_data;
   logic                mem_rd_en;
   logic [ADDR_W-1:0]   mem_rd_addr;
   logic [TAKEN_W-1:0]  mem_rd_data;
   logic [GROUP_W-1:0]  unit_left;
   unit_res_type        unit_res;

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_rows_ff  <= ROWS_RESET;
         csr_seats_ff <= SEATS_RESET;
      end else begin
         csr_rows_ff  <= csr_rows_in;
         csr_seats_ff <= csr_seats_in;
      end
   end

   always_comb begin
      csr_rows_in  = csr_rows_ff;
      csr_seats_in = csr_seats_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_ROWS_IN_USE:   csr_rows_in  = csr_wr_data[ROWCNT_W-1:0];
            CSR_SEATS_PER_ROW: csr_seats_in = csr_wr_data[TAKEN_W-1:0];
            default:           csr_rows_in  = csr_rows_ff;
         endcase
      end
   end

   // clamp the registers to the built capacity
   assign rows_eff  = (32'(csr_rows_ff) < MAX_ROWS) ? csr_rows_ff : ROWCNT_W'(MAX_ROWS);
   assign seats_eff = (32'(csr_seats_ff) < MAX_SEATS) ? csr_seats_ff : TAKEN_W'(MAX_SEATS);

   rsga_row_mem #(
      .DEPTH  (MEM_ROWS),
      .ADDR_W (ADDR_W)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   rsga_free_unit u_unit (
      .seats (seats_eff),
      .taken (mem_rd_data),
      .left  (unit_left),
      .res   (unit_res)
   );

   rsga_seq #(
      .MEM_ROWS (MEM_ROWS),
      .ADDR_W   (ADDR_W)
   ) u_seq (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_type       (req_type),
      .req_group_size (req_group_size),
      .req_max_row    (req_max_row),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_granted    (rsp_granted),
      .rsp_first_row  (rsp_first_row),
      .rsp_first_seat (rsp_first_seat),
      .rows_eff       (rows_eff),
      .mem_wr_en      (mem_wr_en),
      .mem_wr_addr    (mem_wr_addr),
      .mem_wr_data    (mem_wr_data),
      .mem_rd_en      (mem_rd_en),
      .mem_rd_addr    (mem_rd_addr),
      .mem_rd_data    (mem_rd_data),
      .unit_left      (unit_left),
      .unit_res       (unit_res)
   );

endmodule

[sv/rsga_row_mem.sv]
// Per-row taken-seat count memory, one write and one registered read port.
module rsga_row_mem #(
   parameter int DEPTH = 64,
   parameter int ADDR_W = 6
) (
   input  logic                        clock,
   input  logic                        wr_en,
   input  logic [ADDR_W-1:0]           wr_addr,
   input  logic [rsga_pkg::TAKEN_W-1:0] wr_data,
   input  logic                        rd_en,
   input  logic [ADDR_W-1:0]           rd_addr,
   output logic [rsga_pkg::TAKEN_W-1:0] rd_data
);
   import rsga_pkg::*;

   logic [TAKEN_W-1:0] mem_ff [DEPTH];
   logic [TAKEN_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[sv/rsga_free_unit.sv]
// Shared row unit: free seats of a row, fit test and seats taken from it.
module rsga_free_unit (
   input  logic [rsga_pkg::TAKEN_W-1:0] seats,
   input  logic [rsga_pkg::TAKEN_W-1:0] taken,
   input  logic [rsga_pkg::GROUP_W-1:0] left,
   output rsga_pkg::unit_res_type       res
);
   import rsga_pkg::*;

   logic [TAKEN_W-1:0] free_seats;
   logic [TAKEN_W-1:0] take;
   logic               fits;

   always_comb begin
      // saturate: registers may shrink below an existing count
      free_seats = (seats > taken) ? (seats - taken) : '0;
      fits       = (GROUP_W'(free_seats) >= left);
      take       = fits ? left[TAKEN_W-1:0] : free_seats;
      res.fits      = fits;
      res.left_next = left - GROUP_W'(take);
      res.new_taken = taken + take;
   end

endmodule

[sv/rsga_seq.sv]
// Sequencer: clearing pass, row scans, count updates and the result register.
module rsga_seq #(
   parameter int MEM_ROWS = 64,
   parameter int ADDR_W = 6
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_type,
   input  logic [rsga_pkg::GROUP_W-1:0]  req_group_size,
   input  logic [rsga_pkg::ROWNUM_W-1:0] req_max_row,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_granted,
   output logic [rsga_pkg::ROWNUM_W-1:0] rsp_first_row,
   output logic [rsga_pkg::SEAT_W-1:0]   rsp_first_seat,
   input  logic [rsga_pkg::ROWCNT_W-1:0] rows_eff,
   output logic                          mem_wr_en,
   output logic [ADDR_W-1:0]             mem_wr_addr,
   output logic [rsga_pkg::TAKEN_W-1:0]  mem_wr_data,
   output logic                          mem_rd_en,
   output logic [ADDR_W-1:0]             mem_rd_addr,
   input  logic [rsga_pkg::TAKEN_W-1:0]  mem_rd_data,
   output logic [rsga_pkg::GROUP_W-1:0]  unit_left,
   input  rsga_pkg::unit_res_type        unit_res
);
   import rsga_pkg::*;

   localparam logic [ROWNUM_W-1:0] CLR_LAST = ROWNUM_W'(MEM_ROWS - 1);

   state_type           state_ff, state_in;
   logic [ROWNUM_W-1:0] clr_ff, clr_in;
   logic [ROWCNT_W-1:0] issue_ff, issue_in;
   logic                ev_vld_ff, ev_vld_in;
   logic [ROWNUM_W-1:0] ev_row_ff, ev_row_in;
   logic [ROWNUM_W-1:0] top_ff, top_in;
   logic [GROUP_W-1:0]  want_ff, want_in;
   logic [GROUP_W-1:0]  left_ff, left_in;
   logic                res_granted_ff, res_granted_in;
   logic [ROWNUM_W-1:0] res_row_ff, res_row_in;
   logic [SEAT_W-1:0]   res_seat_ff, res_seat_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_granted_ff, rsp_granted_in;
   logic [ROWNUM_W-1:0] rsp_row_ff, rsp_row_in;
   logic [SEAT_W-1:0]   rsp_seat_ff, rsp_seat_in;

   logic                scan;
   logic                stop;
   logic                ev_last;
   logic [ROWCNT_W-1:0] rows_m1;
   logic [ROWNUM_W-1:0] top_clamped;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         ev_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         ev_vld_ff    <= ev_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      issue_ff       <= issue_in;
      ev_row_ff      <= ev_row_in;
      top_ff         <= top_in;
      want_ff        <= want_in;
      left_ff        <= left_in;
      res_granted_ff <= res_granted_in;
      res_row_ff     <= res_row_in;
      res_seat_ff    <= res_seat_in;
      rsp_granted_ff <= rsp_granted_in;
      rsp_row_ff     <= rsp_row_in;
      rsp_seat_ff    <= rsp_seat_in;
   end

   always_comb begin
      rows_m1     = rows_eff - 1'b1;
      top_clamped = ({1'b0, req_max_row} > rows_m1) ? rows_m1[ROWNUM_W-1:0] : req_max_row;
      ev_last     = (ev_row_ff == top_ff);
      scan        = (state_ff == ST_GATHER) || (state_ff == ST_SUM) || (state_ff == ST_FILL);
   end

   always_comb begin
      state_in       = state_ff;
      clr_in         = clr_ff;
      issue_in       = issue_ff;
      top_in         = top_ff;
      want_in        = want_ff;
      left_in        = left_ff;
      res_granted_in = res_granted_ff;
      res_row_in     = res_row_ff;
      res_seat_in    = res_seat_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_granted_in = rsp_granted_ff;
      rsp_row_in     = rsp_row_ff;
      rsp_seat_in    = rsp_seat_ff;
      mem_wr_en      = 1'b0;
      mem_wr_addr    = ADDR_W'(ev_row_ff);
      mem_wr_data    = unit_res.new_taken;
      mem_rd_en      = 1'b0;
      mem_rd_addr    = ADDR_W'(issue_ff[ROWNUM_W-1:0]);
      stop           = 1'b0;

      unique case (state_ff)
         ST_CLEAR: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = ADDR_W'(clr_ff);
            mem_wr_data = '0;
            clr_in      = clr_ff + 1'b1;
            if (clr_ff == CLR_LAST) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               want_in        = req_group_size;
               left_in        = req_group_size;
               top_in         = top_clamped;
               issue_in       = '0;
               res_granted_in = 1'b0;
               res_row_in     = '0;
               res_seat_in    = '0;
               if ((rows_eff == '0) || (req_group_size == '0)) begin
                  state_in = ST_DONE;
               end else if (req_type == REQ_SCATTER) begin
                  state_in = ST_SUM;
               end else begin
                  state_in = ST_GATHER;
               end
            end
         end
         ST_GATHER: begin
            if (ev_vld_ff) begin
               if (unit_res.fits) begin
                  mem_wr_en      = 1'b1;
                  res_granted_in = 1'b1;
                  res_row_in     = ev_row_ff;
                  res_seat_in    = mem_rd_data[SEAT_W-1:0];
                  stop           = 1'b1;
                  state_in       = ST_DONE;
               end else if (ev_last) begin
                  stop     = 1'b1;
                  state_in = ST_DONE;
               end
            end
         end
         ST_SUM: begin
            // count down the request against free space; no writes yet
            if (ev_vld_ff) begin
               left_in = unit_res.left_next;
               if (unit_res.left_next == '0) begin
                  stop     = 1'b1;
                  left_in  = want_ff;
                  issue_in = '0;
                  state_in = ST_FILL;
               end else if (ev_last) begin
                  stop     = 1'b1;
                  state_in = ST_DONE;
               end
            end
         end
         ST_FILL: begin
            if (ev_vld_ff) begin
               mem_wr_en = 1'b1;
               left_in   = unit_res.left_next;
               if ((unit_res.left_next == '0) || ev_last) begin
                  res_granted_in = 1'b1;
                  stop           = 1'b1;
                  state_in       = ST_DONE;
               end
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in   = 1'b1;
               rsp_granted_in = res_granted_ff;
               rsp_row_in     = res_row_ff;
               rsp_seat_in    = res_seat_ff;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // stream one row read per cycle while the scan goes on
      if (scan && !stop && (issue_ff <= {1'b0, top_ff})) begin
         mem_rd_en = 1'b1;
         issue_in  = issue_ff + 1'b1;
      end
   end

   assign ev_vld_in      = mem_rd_en;
   assign ev_row_in      = issue_ff[ROWNUM_W-1:0];
   assign unit_left      = left_ff;
   assign req_stall      = (state_ff != ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_granted    = rsp_granted_ff;
   assign rsp_first_row  = rsp_row_ff;
   assign rsp_first_seat = rsp_seat_ff;

endmodule

[sv/rsga_checker.sv]
// Port-level checks for the row seat group allocator, bound to the top level.
module rsga_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_stall,
   input logic                            rsp_valid,
   input logic                            rsp_stall,
   input logic                            rsp_granted,
   input logic [rsga_pkg::ROWNUM_W-1:0]   rsp_first_row,
   input logic [rsga_pkg::SEAT_W-1:0]     rsp_first_seat
);

   // hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_granted)
         && $stable(rsp_first_row) && $stable(rsp_first_seat))
      else $error("result changed while stalled");

   // a denial carries no row or seat
   a_deny_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_granted |-> (rsp_first_row == '0) && (rsp_first_seat == '0))
      else $error("denied result with nonzero row or seat");

   // the clearing pass blocks requests and shows no result
   a_reset_busy: assert property (@(posedge clock)
      reset |=> req_stall && !rsp_valid)
      else $error("not busy after reset");

   // one item at a time: busy right after an item is taken
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second item taken without a busy cycle");

endmodule

bind row_seat_group_allocator_top rsga_checker u_rsga_checker (.*);
